[design/mecanum_wheel_mix_desaturate_macros.svh]
`ifndef MECANUM_WHEEL_MIX_DESATURATE_MACROS_SVH
`define MECANUM_WHEEL_MIX_DESATURATE_MACROS_SVH

// Check that a condition holds at every edge out of reset
`define MWMD_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed");

// Check that a condition in one cycle implies another in the next cycle
`define MWMD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[design/mwmd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mwmd_pkg;

  localparam int SPEED_WIDTH     = 16;
  localparam int RATE_WIDTH      = 24;
  localparam int GAIN_WIDTH      = 24;
  localparam int STRAFE_WIDTH    = 23;
  localparam int LIMIT_WIDTH     = 23;
  localparam int MIX_SHIFT       = 12;
  localparam int WHEELS          = 4;
  localparam int PROD_WIDTH      = GAIN_WIDTH + SPEED_WIDTH;
  localparam int SUM_WIDTH       = PROD_WIDTH + 2;
  localparam int SHIFT_WIDTH     = SUM_WIDTH - MIX_SHIFT;
  localparam int MAG_WIDTH       = RATE_WIDTH;
  localparam int NUM_WIDTH       = MAG_WIDTH + LIMIT_WIDTH;
  localparam int QUO_WIDTH       = LIMIT_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 24;
  localparam int MQ_DEPTH        = 4;
  localparam int MQ_PTR_WIDTH    = 2;
  localparam int OQ_DEPTH        = 32;
  localparam int OQ_PTR_WIDTH    = 5;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_FORWARD_GAIN = 3'd0,
    REG_STRAFE_GAIN  = 3'd1,
    REG_YAW_GAIN     = 3'd2,
    REG_WHEEL_LIMIT  = 3'd3,
    REG_GEOMETRY_OK  = 3'd4
  } cfg_reg_t;

  typedef logic signed [RATE_WIDTH-1:0] rate_t;
  typedef logic [MAG_WIDTH-1:0] mag_t;

  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0] forward_gain;
    logic [STRAFE_WIDTH-1:0]      strafe_gain;
    logic signed [GAIN_WIDTH-1:0] yaw_gain;
    logic [LIMIT_WIDTH-1:0]       wheel_limit;
    logic                         geometry_ok;
  } cfg_t;

  typedef struct packed {
    rate_t [WHEELS-1:0] rate;
    mag_t [WHEELS-1:0]  mag;
    mag_t               largest;
    logic               scaled;
    logic               invalid;
  } mix_word_t;

  typedef struct packed {
    rate_t [WHEELS-1:0] rate;
    logic               was_scaled;
    logic               invalid_setup;
  } result_word_t;

endpackage
`default_nettype wire

[design/mecanum_wheel_mix_desaturate.sv]
`timescale 1ns / 1ps
`default_nettype none
// Mecanum wheel mixer with desaturation.
// Input channel: push with full; a command (forward_speed, strafe_speed,
// yaw_rate) is taken at an edge with push high and full low.
// Result channel: empty with pop; the oldest result sits on the rate,
// was_scaled and invalid_setup ports while empty is low and leaves on an
// edge with pop high.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Write registers only while no command is in flight.
// Throughput: one command per cycle while full is low. A result passes
// through the three mix stages, the hand-off queue, the numerator multiply
// and the 23-stage bit-per-stage divider.
// Up to 32 commands may be in flight or waiting; full rises when the
// 32-entry result queue could not take all of them, so a stalled receiver
// backs the input up without losing a word.
// Reset clears the configuration registers to zero (invalid setup), empties both queues.
module mecanum_wheel_mix_desaturate (
  input  wire                                          clk,
  input  wire                                          rst,
  input  wire                                          cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [mwmd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [mwmd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  input  wire                                          push,
  output logic                                         full,
  input  wire logic signed [mwmd_pkg::SPEED_WIDTH-1:0] forward_speed,
  input  wire logic signed [mwmd_pkg::SPEED_WIDTH-1:0] strafe_speed,
  input  wire logic signed [mwmd_pkg::SPEED_WIDTH-1:0] yaw_rate,
  output logic                                         empty,
  input  wire                                          pop,
  output logic signed [mwmd_pkg::RATE_WIDTH-1:0]       front_left_rate,
  output logic signed [mwmd_pkg::RATE_WIDTH-1:0]       front_right_rate,
  output logic signed [mwmd_pkg::RATE_WIDTH-1:0]       back_left_rate,
  output logic signed [mwmd_pkg::RATE_WIDTH-1:0]       back_right_rate,
  output logic                                         was_scaled,
  output logic                                         invalid_setup
);
  import mwmd_pkg::*;
  `include "mecanum_wheel_mix_desaturate_macros.svh"

  cfg_t                     cfg;
  logic                     take, give;
  logic [OQ_PTR_WIDTH:0]    credit;
  mix_word_t                mix_word;
  logic                     mix_valid;
  result_word_t             res_word;
  logic                     res_valid;
  result_word_t             oq_mem [OQ_DEPTH];
  logic [OQ_PTR_WIDTH-1:0]  oq_wp, oq_rp;
  logic [OQ_PTR_WIDTH:0]    oq_count;
  result_word_t             head;

  assign cfg_ready = 1'b1;
  assign full      = (credit == (OQ_PTR_WIDTH+1)'(OQ_DEPTH));
  assign empty     = (oq_count == '0);
  assign take      = push && !full;
  assign give      = pop && !empty;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FORWARD_GAIN: cfg.forward_gain <= cfg_data[GAIN_WIDTH-1:0];
        REG_STRAFE_GAIN:  cfg.strafe_gain  <= cfg_data[STRAFE_WIDTH-1:0];
        REG_YAW_GAIN:     cfg.yaw_gain     <= cfg_data[GAIN_WIDTH-1:0];
        REG_WHEEL_LIMIT:  cfg.wheel_limit  <= cfg_data[LIMIT_WIDTH-1:0];
        REG_GEOMETRY_OK:  cfg.geometry_ok  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Count words taken but not yet popped
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + (OQ_PTR_WIDTH+1)'(take) - (OQ_PTR_WIDTH+1)'(give);
    end
  end

  mwmd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (take),
    .forward_speed (forward_speed),
    .strafe_speed  (strafe_speed),
    .yaw_rate      (yaw_rate),
    .out_valid     (mix_valid),
    .out_word      (mix_word)
  );

  mwmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .wheel_limit (cfg.wheel_limit),
    .in_valid    (mix_valid),
    .in_word     (mix_word),
    .out_valid   (res_valid),
    .out_word    (res_word)
  );

  // Hold finished words until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp    <= '0;
      oq_rp    <= '0;
      oq_count <= '0;
    end else begin
      if (res_valid) oq_wp <= oq_wp + 1'b1;
      if (give) oq_rp <= oq_rp + 1'b1;
      oq_count <= oq_count + (OQ_PTR_WIDTH+1)'(res_valid) - (OQ_PTR_WIDTH+1)'(give);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) oq_mem[oq_wp] <= res_word;
  end

  assign head             = oq_mem[oq_rp];
  assign front_left_rate  = head.rate[0];
  assign front_right_rate = head.rate[1];
  assign back_left_rate   = head.rate[2];
  assign back_right_rate  = head.rate[3];
  assign was_scaled       = head.was_scaled;
  assign invalid_setup    = head.invalid_setup;

  `MWMD_ASSERT_ALWAYS(a_credit_bound, credit <= (OQ_PTR_WIDTH+1)'(OQ_DEPTH))
  `MWMD_ASSERT_ALWAYS(a_queue_in_credit, oq_count <= credit)
  `MWMD_ASSERT_NEXT(a_credit_up, take && !give, credit == $past(credit) + 1'b1)

endmodule
`default_nettype wire

[design/mwmd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module mwmd_front (
  input  wire                                        clk,
  input  wire                                        rst,
  input  mwmd_pkg::cfg_t                             cfg,
  input  wire                                        in_valid,
  input  wire logic signed [mwmd_pkg::SPEED_WIDTH-1:0] forward_speed,
  input  wire logic signed [mwmd_pkg::SPEED_WIDTH-1:0] strafe_speed,
  input  wire logic signed [mwmd_pkg::SPEED_WIDTH-1:0] yaw_rate,
  output logic                                       out_valid,
  output mwmd_pkg::mix_word_t                        out_word
);
  import mwmd_pkg::*;

  localparam logic signed [SHIFT_WIDTH-1:0] SAT_HI =
    SHIFT_WIDTH'((64'sd1 <<< (RATE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SHIFT_WIDTH-1:0] SAT_LO = ~SAT_HI;

  logic                           v1, v2;
  logic                           inv1, inv2;
  logic signed [PROD_WIDTH-1:0]   fx, sy, yw;
  rate_t                          rate2 [WHEELS];
  logic signed [SUM_WIDTH-1:0]    sum   [WHEELS];
  logic signed [SHIFT_WIDTH-1:0]  shd   [WHEELS];
  rate_t                          sat   [WHEELS];
  mag_t                           mag   [WHEELS];
  mag_t                           max01, max23, largest;

  // Mix the three products per wheel, floor to rate format and saturate
  always_comb begin
    sum[0] = SUM_WIDTH'(fx) + SUM_WIDTH'(sy) - SUM_WIDTH'(yw);
    sum[1] = SUM_WIDTH'(fx) - SUM_WIDTH'(sy) + SUM_WIDTH'(yw);
    sum[2] = SUM_WIDTH'(fx) - SUM_WIDTH'(sy) - SUM_WIDTH'(yw);
    sum[3] = SUM_WIDTH'(fx) + SUM_WIDTH'(sy) + SUM_WIDTH'(yw);
    for (int k = 0; k < WHEELS; k++) begin
      shd[k] = SHIFT_WIDTH'(sum[k] >>> MIX_SHIFT);
      if (shd[k] > SAT_HI) begin
        sat[k] = RATE_WIDTH'(SAT_HI);
      end else if (shd[k] < SAT_LO) begin
        sat[k] = RATE_WIDTH'(SAT_LO);
      end else begin
        sat[k] = RATE_WIDTH'(shd[k]);
      end
    end
  end

  // Take magnitudes and find the largest
  always_comb begin
    for (int k = 0; k < WHEELS; k++) begin
      mag[k] = rate2[k][RATE_WIDTH-1] ? MAG_WIDTH'(-rate2[k]) : MAG_WIDTH'(rate2[k]);
    end
    max01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
    max23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
    largest = (max01 > max23) ? max01 : max23;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Products, mixed rates, then classified word
  always_ff @(posedge clk) begin
    fx   <= cfg.forward_gain * forward_speed;
    sy   <= $signed({1'b0, cfg.strafe_gain}) * strafe_speed;
    yw   <= cfg.yaw_gain * yaw_rate;
    inv1 <= !cfg.geometry_ok || (cfg.wheel_limit == '0);
    for (int k = 0; k < WHEELS; k++) begin
      rate2[k] <= sat[k];
      out_word.rate[k] <= rate2[k];
      out_word.mag[k]  <= mag[k];
    end
    inv2             <= inv1;
    out_word.largest <= largest;
    out_word.invalid <= inv2;
    out_word.scaled  <= !inv2 && (largest > {1'b0, cfg.wheel_limit});
  end

endmodule
`default_nettype wire

[design/mwmd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module mwmd_back (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire logic [mwmd_pkg::LIMIT_WIDTH-1:0]   wheel_limit,
  input  wire                                     in_valid,
  input  mwmd_pkg::mix_word_t                     in_word,
  output logic                                    out_valid,
  output mwmd_pkg::result_word_t                  out_word
);
  import mwmd_pkg::*;
  `include "mecanum_wheel_mix_desaturate_macros.svh"

  mix_word_t                mq_mem [MQ_DEPTH];
  logic [MQ_PTR_WIDTH-1:0]  mq_wp, mq_rp;
  logic [MQ_PTR_WIDTH:0]    mq_count;
  logic                     mq_pop;

  logic [QUO_WIDTH:0]       div_valid;
  mix_word_t                div_word [QUO_WIDTH+1];
  logic [NUM_WIDTH-1:0]     div_rem  [QUO_WIDTH+1][WHEELS];
  logic [QUO_WIDTH-1:0]     div_quo  [QUO_WIDTH+1][WHEELS];
  logic [NUM_WIDTH-1:0]     rem_next [QUO_WIDTH][WHEELS];
  logic                     bit_next [QUO_WIDTH][WHEELS];
  mix_word_t                tail;

  assign mq_pop = (mq_count != '0);

  // Hold words from the front until the divider takes them
  always_ff @(posedge clk) begin
    if (rst) begin
      mq_wp    <= '0;
      mq_rp    <= '0;
      mq_count <= '0;
    end else begin
      if (in_valid) mq_wp <= mq_wp + 1'b1;
      if (mq_pop) mq_rp <= mq_rp + 1'b1;
      mq_count <= mq_count + (MQ_PTR_WIDTH+1)'(in_valid) - (MQ_PTR_WIDTH+1)'(mq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) mq_mem[mq_wp] <= in_word;
  end

  // One quotient bit per stage for each wheel
  always_comb begin
    logic [NUM_WIDTH-1:0] trial;
    for (int s = 0; s < QUO_WIDTH; s++) begin
      for (int k = 0; k < WHEELS; k++) begin
        trial = NUM_WIDTH'(div_word[s].largest) << (QUO_WIDTH - 1 - s);
        bit_next[s][k] = (div_rem[s][k] >= trial);
        rem_next[s][k] = bit_next[s][k] ? div_rem[s][k] - trial : div_rem[s][k];
      end
    end
  end

  // Advance valid bits through the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      div_valid <= {div_valid[QUO_WIDTH-1:0], mq_pop};
      out_valid <= div_valid[QUO_WIDTH];
    end
  end

  // Form numerators, then divide by the largest magnitude
  always_ff @(posedge clk) begin
    div_word[0] <= mq_mem[mq_rp];
    for (int k = 0; k < WHEELS; k++) begin
      div_rem[0][k] <= mq_mem[mq_rp].mag[k] * wheel_limit;
      div_quo[0][k] <= '0;
    end
    for (int s = 0; s < QUO_WIDTH; s++) begin
      div_word[s+1] <= div_word[s];
      for (int k = 0; k < WHEELS; k++) begin
        div_rem[s+1][k] <= rem_next[s][k];
        div_quo[s+1][k] <= {div_quo[s][k][QUO_WIDTH-2:0], bit_next[s][k]};
      end
    end
  end

  assign tail = div_word[QUO_WIDTH];

  // Pick the passed, scaled or zeroed rates
  always_ff @(posedge clk) begin
    for (int k = 0; k < WHEELS; k++) begin
      if (tail.invalid) begin
        out_word.rate[k] <= '0;
      end else if (tail.scaled) begin
        out_word.rate[k] <= tail.rate[k][RATE_WIDTH-1]
          ? RATE_WIDTH'(-$signed({1'b0, div_quo[QUO_WIDTH][k]}))
          : RATE_WIDTH'({1'b0, div_quo[QUO_WIDTH][k]});
      end else begin
        out_word.rate[k] <= tail.rate[k];
      end
    end
    out_word.was_scaled    <= tail.scaled && !tail.invalid;
    out_word.invalid_setup <= tail.invalid;
  end

  `MWMD_ASSERT_ALWAYS(a_mq_bound, mq_count <= (MQ_PTR_WIDTH+1)'(MQ_DEPTH))
  `MWMD_ASSERT_NEXT(a_mq_drain, in_valid, mq_count != '0)
  `MWMD_ASSERT_ALWAYS(a_invalid_zero, !(out_valid && out_word.invalid_setup) || (out_word.rate == '0 && !out_word.was_scaled))

endmodule
`default_nettype wire
